[rtl/bsi_pkg.sv]
package bsi_pkg;

    localparam int NUM_REG_DIMS = 4;
    localparam int DIM_W        = 16;
    localparam int IDX_W        = 32;
    localparam int CNT_W        = IDX_W + 1;
    localparam int CFG_IDX_W    = 4;

    localparam logic [CNT_W-1:0] COUNT_CAP = {1'b1, {IDX_W{1'b0}}};

    // One transaction in flight: partial remainder, dividend/quotient, source sum, flags.
    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic [IDX_W-1:0] num;
        logic [IDX_W-1:0] acc;
        logic             incompat;
        logic             oor;
    } item_t;

    // Product that saturates at 2^32; a saturated value times zero is zero.
    function automatic logic [CNT_W-1:0] sat_mul(input logic [CNT_W-1:0] a,
                                                 input logic [DIM_W-1:0] d);
        logic [IDX_W+DIM_W-1:0] p;
        logic [CNT_W-1:0]       r;
        p = a[IDX_W-1:0] * d;
        if (d == '0)
        begin
            r = '0;
        end
        else if (a[IDX_W])
        begin
            r = COUNT_CAP;
        end
        else if (p > {{(DIM_W-1){1'b0}}, COUNT_CAP})
        begin
            r = COUNT_CAP;
        end
        else
        begin
            r = p[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/bsi_shape.sv]
module bsi_shape #(
    parameter int MAX_RANK = 4
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic [bsi_pkg::NUM_REG_DIMS-1:0][bsi_pkg::DIM_W-1:0] src_dims,
    input  logic [bsi_pkg::NUM_REG_DIMS-1:0][bsi_pkg::DIM_W-1:0] tgt_dims,
    output logic [MAX_RANK-1:0][bsi_pkg::DIM_W-1:0]          bdim,
    output logic [MAX_RANK-1:0]                              sone,
    output logic [MAX_RANK-1:0][bsi_pkg::IDX_W-1:0]          stride,
    output logic [bsi_pkg::CNT_W-1:0]                        count,
    output logic                                             incompat
);
    import bsi_pkg::*;

    localparam int OFS = NUM_REG_DIMS - MAX_RANK;

    logic [MAX_RANK-1:0][DIM_W-1:0] s_dim;
    logic [MAX_RANK-1:0][DIM_W-1:0] t_dim;
    logic [MAX_RANK-1:0][DIM_W-1:0] b_dim;
    logic [MAX_RANK-1:0]            bad;

    logic [MAX_RANK-1:0][DIM_W-1:0] bdim_reg;
    logic [MAX_RANK-1:0][DIM_W-1:0] sdim_reg;
    logic                           incompat_reg;
    logic [CNT_W-1:0]               cnt_reg [MAX_RANK];
    logic [CNT_W-1:0]               str_reg [MAX_RANK];

    genvar a;
    generate
        for (a = 0; a < MAX_RANK; a++)
        begin : g_axis
            if (a + OFS >= 0 && a + OFS < NUM_REG_DIMS)
            begin : g_reg
                assign s_dim[a] = src_dims[a + OFS];
                assign t_dim[a] = tgt_dims[a + OFS];
            end
            else
            begin : g_pad
                assign s_dim[a] = DIM_W'(1);
                assign t_dim[a] = DIM_W'(1);
            end

            always_comb
            begin
                bad[a] = 1'b0;
                if (s_dim[a] == t_dim[a] || t_dim[a] == DIM_W'(1))
                begin
                    b_dim[a] = s_dim[a];
                end
                else if (s_dim[a] == DIM_W'(1))
                begin
                    b_dim[a] = t_dim[a];
                end
                else
                begin
                    b_dim[a] = t_dim[a];
                    bad[a]   = 1'b1;
                end
            end

            assign bdim[a]   = bdim_reg[a];
            assign sone[a]   = (sdim_reg[a] == DIM_W'(1));
            assign stride[a] = str_reg[a][IDX_W] ? '0 : str_reg[a][IDX_W-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bdim_reg     <= '0;
            sdim_reg     <= '0;
            incompat_reg <= 1'b0;
        end
        else
        begin
            bdim_reg     <= b_dim;
            sdim_reg     <= s_dim;
            incompat_reg <= |bad;
        end
    end

    // Element count and source strides settle one axis per cycle.
    always_ff @(posedge clk)
    begin
        cnt_reg[0]          <= sat_mul(CNT_W'(1), bdim_reg[0]);
        str_reg[MAX_RANK-1] <= CNT_W'(1);
        for (int k = 1; k < MAX_RANK; k++)
        begin
            cnt_reg[k] <= sat_mul(cnt_reg[k-1], bdim_reg[k]);
        end
        for (int k = 0; k < MAX_RANK - 1; k++)
        begin
            str_reg[k] <= sat_mul(str_reg[k+1], sdim_reg[k+1]);
        end
    end

    assign count    = cnt_reg[MAX_RANK-1];
    assign incompat = incompat_reg;

endmodule

[rtl/bsi_axis.sv]
module bsi_axis (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_vld,
    input  bsi_pkg::item_t              in_item,
    input  logic [bsi_pkg::DIM_W-1:0]   bdim,
    input  logic                        sone,
    input  logic [bsi_pkg::IDX_W-1:0]   stride,
    output logic                        out_vld,
    output bsi_pkg::item_t              out_item
);
    import bsi_pkg::*;

    localparam int NDIV = IDX_W;

    logic  [NDIV-1:0]       div_vld_reg;
    item_t                  div_reg [NDIV];
    item_t                  div_next [NDIV];
    logic                   mul_vld_reg;
    item_t                  mul_reg;
    item_t                  mul_next;
    logic  [IDX_W-1:0]      prod_reg;
    logic                   acc_vld_reg;
    item_t                  acc_reg;
    item_t                  acc_next;
    logic  [IDX_W+DIM_W-1:0] prod_full;

    // One restoring division step per stage: quotient bits shift in at the bottom.
    genvar k;
    generate
        for (k = 0; k < NDIV; k++)
        begin : g_step
            item_t          src;
            logic [DIM_W:0] trial;
            if (k == 0)
            begin : g_first
                assign src = in_item;
            end
            else
            begin : g_rest
                assign src = div_reg[k-1];
            end
            assign trial = {src.rem, src.num[IDX_W-1]};
            always_comb
            begin
                div_next[k] = src;
                if (trial >= {1'b0, bdim})
                begin
                    div_next[k].rem = DIM_W'(trial - {1'b0, bdim});
                    div_next[k].num = {src.num[IDX_W-2:0], 1'b1};
                end
                else
                begin
                    div_next[k].rem = trial[DIM_W-1:0];
                    div_next[k].num = {src.num[IDX_W-2:0], 1'b0};
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    div_reg[k] <= div_next[k];
                end
            end
        end
    endgenerate

    assign prod_full = (sone ? {DIM_W{1'b0}} : div_reg[NDIV-1].rem) * stride;

    always_comb
    begin
        mul_next     = div_reg[NDIV-1];
        mul_next.rem = '0;
        acc_next     = mul_reg;
        acc_next.acc = mul_reg.acc + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
            mul_vld_reg <= 1'b0;
            acc_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            div_vld_reg <= {div_vld_reg[NDIV-2:0], in_vld};
            mul_vld_reg <= div_vld_reg[NDIV-1];
            acc_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_reg  <= mul_next;
            prod_reg <= prod_full[IDX_W-1:0];
            acc_reg  <= acc_next;
        end
    end

    assign out_vld  = acc_vld_reg;
    assign out_item = acc_reg;

endmodule

[rtl/broadcast_source_index.sv]
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in        in         in_valid/in_stall     result_index
// out       out        out_valid/out_stall   source_index, shapes_incompatible,
//                                            index_out_of_range
//
// One transaction is accepted per cycle unless in_stall is high; each axis divides
// one bit per stage, then passes through its multiply and add stages.
// After reset and after a register write the input stalls while the element count
// and strides settle through their per-axis registers.
// Reset returns all dimensions to 1 and empties the pipeline.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module broadcast_source_index #(
    parameter int MAX_RANK = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsi_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bsi_pkg::IDX_W-1:0]     result_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bsi_pkg::IDX_W-1:0]     source_index,
    output logic                          shapes_incompatible,
    output logic                          index_out_of_range
);
    import bsi_pkg::*;

    localparam int SET_W = $clog2(MAX_RANK + 4);
    localparam logic [SET_W-1:0] SETTLE = SET_W'(MAX_RANK + 2);

    logic [NUM_REG_DIMS-1:0][DIM_W-1:0] src_reg;
    logic [NUM_REG_DIMS-1:0][DIM_W-1:0] tgt_reg;
    logic [SET_W-1:0]                   settle_reg;

    logic [MAX_RANK-1:0][DIM_W-1:0] bdim;
    logic [MAX_RANK-1:0]            sone;
    logic [MAX_RANK-1:0][IDX_W-1:0] stride;
    logic [CNT_W-1:0]               count;
    logic                           incompat;

    logic  adv;
    logic  accept;
    logic  ent_vld_reg;
    item_t ent_reg;
    logic  [MAX_RANK:0] ax_vld;
    item_t ax_item [MAX_RANK+1];
    logic  out_vld_reg;
    logic  [IDX_W-1:0] src_out_reg;
    logic  incompat_out_reg;
    logic  oor_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REG_DIMS; i++)
            begin
                src_reg[i] <= DIM_W'(1);
                tgt_reg[i] <= DIM_W'(1);
            end
            settle_reg <= SETTLE;
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < NUM_REG_DIMS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    src_reg[i] <= cfg_data;
                end
                if (cfg_index == CFG_IDX_W'(i + NUM_REG_DIMS))
                begin
                    tgt_reg[i] <= cfg_data;
                end
            end
            settle_reg <= SETTLE;
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - SET_W'(1);
        end
    end

    bsi_shape #(
        .MAX_RANK (MAX_RANK)
    ) u_shape (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_dims (src_reg),
        .tgt_dims (tgt_reg),
        .bdim     (bdim),
        .sone     (sone),
        .stride   (stride),
        .count    (count),
        .incompat (incompat)
    );

    assign adv      = !(out_vld_reg && out_stall);
    assign in_stall = !adv || (settle_reg != '0);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            ent_vld_reg <= accept;
            out_vld_reg <= ax_vld[MAX_RANK];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent_reg.rem      <= '0;
            ent_reg.num      <= result_index;
            ent_reg.acc      <= '0;
            ent_reg.incompat <= incompat;
            ent_reg.oor      <= ({1'b0, result_index} >= count);
            src_out_reg      <= (ax_item[MAX_RANK].incompat || ax_item[MAX_RANK].oor) ?
                                '0 : ax_item[MAX_RANK].acc;
            incompat_out_reg <= ax_item[MAX_RANK].incompat;
            oor_out_reg      <= ax_item[MAX_RANK].oor;
        end
    end

    assign ax_vld[0]  = ent_vld_reg;
    assign ax_item[0] = ent_reg;

    // Axes are peeled innermost first, each quotient feeding the next axis.
    genvar j;
    generate
        for (j = 0; j < MAX_RANK; j++)
        begin : g_ax
            bsi_axis u_axis (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .in_vld   (ax_vld[j]),
                .in_item  (ax_item[j]),
                .bdim     (bdim[MAX_RANK-1-j]),
                .sone     (sone[MAX_RANK-1-j]),
                .stride   (stride[MAX_RANK-1-j]),
                .out_vld  (ax_vld[j+1]),
                .out_item (ax_item[j+1])
            );
        end
    endgenerate

    assign out_valid           = out_vld_reg;
    assign source_index        = src_out_reg;
    assign shapes_incompatible = incompat_out_reg;
    assign index_out_of_range  = oor_out_reg;

endmodule

[tb/sv/broadcast_source_index_test.sv]
`timescale 1ns / 1ps

module broadcast_source_index_test;

    import bsi_pkg::*;

    localparam int RANK       = 4;
    localparam int LATENCY    = 2 + 34 * RANK;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_DIM_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_DIM_0 = 4'd4;
    localparam int NUM_REGS = 8;

    typedef struct {
        logic [IDX_W-1:0] source_index;
        logic             shapes_incompatible;
        logic             index_out_of_range;
    } mapping_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [IDX_W-1:0]     result_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [IDX_W-1:0]     source_index;
    logic                 shapes_incompatible;
    logic                 index_out_of_range;

    logic [DIM_W-1:0] src_shape [NUM_REG_DIMS];
    logic [DIM_W-1:0] tgt_shape [NUM_REG_DIMS];

    logic [IDX_W-1:0] pending_indices [$];
    mapping_t         expected_mappings [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  idle_cycles;
    int  error_count;

    broadcast_source_index #(.MAX_RANK(RANK)) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .result_index        (result_index),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .source_index        (source_index),
        .shapes_incompatible (shapes_incompatible),
        .index_out_of_range  (index_out_of_range)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic mapping_t map_index(input logic [IDX_W-1:0] idx);
        mapping_t   m;
        logic [63:0] sdim [RANK];
        logic [63:0] bdim [RANK];
        logic [63:0] count;
        logic [63:0] rem;
        logic [63:0] stride;
        logic [63:0] coord;
        logic [63:0] sum;
        logic [63:0] s;
        logic [63:0] t;
        bit          bad;
        int          r;
        count = 1;
        bad = 1'b0;
        sum = 0;
        for (int a = 0; a < RANK; a++)
        begin
            r = a + NUM_REG_DIMS - RANK;
            s = (r < 0 || r >= NUM_REG_DIMS) ? 64'd1 : 64'(src_shape[r]);
            t = (r < 0 || r >= NUM_REG_DIMS) ? 64'd1 : 64'(tgt_shape[r]);
            if (s == t || t == 1)
            begin
                bdim[a] = s;
            end
            else if (s == 1)
            begin
                bdim[a] = t;
            end
            else
            begin
                bdim[a] = t;
                bad = 1'b1;
            end
            sdim[a] = s;
            count = count * bdim[a];
            if (count > 64'h1_0000_0000)
            begin
                count = 64'h1_0000_0000;
            end
        end
        m.shapes_incompatible = bad;
        m.index_out_of_range  = (64'(idx) >= count);
        if (!bad && !m.index_out_of_range)
        begin
            rem = 64'(idx);
            stride = 1;
            for (int a = RANK - 1; a >= 0; a--)
            begin
                coord = rem % bdim[a];
                rem = rem / bdim[a];
                if (sdim[a] == 1)
                begin
                    coord = 0;
                end
                sum = sum + coord * stride;
                stride = stride * sdim[a];
                if (stride > 64'h1_0000_0000)
                begin
                    stride = 64'h1_0000_0000;
                end
            end
        end
        m.source_index = sum[IDX_W-1:0];
        return m;
    endfunction

    // Driver: presents queued indices, holds a stalled payload steady.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            result_index <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                expected_mappings.push_back(map_index(result_index));
            end
            if (pending_indices.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid     <= 1'b1;
                result_index <= pending_indices.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        mapping_t exp_m;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_mappings.size() == 0)
                begin
                    $error("unexpected transaction: source_index %h", source_index);
                    error_count++;
                end
                else
                begin
                    exp_m = expected_mappings.pop_front();
                    if (source_index !== exp_m.source_index)
                    begin
                        $error("source_index expected %h actual %h",
                               exp_m.source_index, source_index);
                        error_count++;
                    end
                    if (shapes_incompatible !== exp_m.shapes_incompatible)
                    begin
                        $error("shapes_incompatible expected %b actual %b",
                               exp_m.shapes_incompatible, shapes_incompatible);
                        error_count++;
                    end
                    if (index_out_of_range !== exp_m.index_out_of_range)
                    begin
                        $error("index_out_of_range expected %b actual %b",
                               exp_m.index_out_of_range, index_out_of_range);
                        error_count++;
                    end
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles with no accepted transaction on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Leaves cfg_valid high so back-to-back writes need no gap; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx < REG_TGT_DIM_0)
        begin
            src_shape[idx] = val;
        end
        else if (idx < NUM_REGS)
        begin
            tgt_shape[idx - REG_TGT_DIM_0] = val;
        end
    endtask

    task automatic wait_drained();
        while (pending_indices.size() > 0 || in_valid || expected_mappings.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_shapes(input logic [DIM_W-1:0] s [NUM_REG_DIMS],
                              input logic [DIM_W-1:0] t [NUM_REG_DIMS]);
        wait_drained();
        for (int i = 0; i < NUM_REG_DIMS; i++)
        begin
            write_reg(REG_SRC_DIM_0 + CFG_IDX_W'(i), s[i]);
            write_reg(REG_TGT_DIM_0 + CFG_IDX_W'(i), t[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_index(input logic [63:0] count);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0 || count == 0)
        begin
            return $urandom();
        end
        else if (sel == 1)
        begin
            return (count > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : count[IDX_W-1:0];
        end
        else if (sel == 2)
        begin
            return (count > 64'h1_0000_0000) ? 32'hFFFF_FFFF : 32'(count - 1);
        end
        else
        begin
            return 32'(({$urandom(), $urandom()}) % count);
        end
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3)
        begin
            return 16'd1;
        end
        else if (sel == 3)
        begin
            return 16'hFFFF;
        end
        else if (sel == 4)
        begin
            return 16'd0;
        end
        else
        begin
            return 16'($urandom_range(2, 40));
        end
    endfunction

    function automatic logic [63:0] target_count();
        logic [63:0] c;
        logic [63:0] b;
        c = 1;
        for (int i = 0; i < NUM_REG_DIMS; i++)
        begin
            b = (src_shape[i] == tgt_shape[i] || tgt_shape[i] == 1) ? src_shape[i]
                                                                    : tgt_shape[i];
            c = c * b;
            if (c > 64'h1_0000_0000)
            begin
                c = 64'h1_0000_0000;
            end
        end
        return c;
    endfunction

    initial
    begin
        logic [DIM_W-1:0] s [NUM_REG_DIMS];
        logic [DIM_W-1:0] t [NUM_REG_DIMS];
        logic [63:0]      cnt;
        int               phase;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        result_index    = '0;
        out_stall       = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        idle_cycles     = 0;
        error_count     = 0;
        for (int i = 0; i < NUM_REG_DIMS; i++)
        begin
            src_shape[i] = 16'd1;
            tgt_shape[i] = 16'd1;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset shapes: one element, so only index 0 is in range.
        pending_indices.push_back(32'd0);
        pending_indices.push_back(32'd1);
        pending_indices.push_back(32'hFFFF_FFFF);

        // Plain broadcast of a row over a matrix.
        s = '{16'd1, 16'd1, 16'd1, 16'd5};
        t = '{16'd1, 16'd1, 16'd3, 16'd5};
        set_shapes(s, t);
        for (int i = 0; i < 16; i += 3)
        begin
            pending_indices.push_back(32'(i));
        end

        // Incompatible pair together with out of range.
        s = '{16'd1, 16'd2, 16'd3, 16'd4};
        t = '{16'd1, 16'd5, 16'd3, 16'd4};
        set_shapes(s, t);
        pending_indices.push_back(32'd7);
        pending_indices.push_back(32'd60);

        // Zero dimension, both compatible and not.
        s = '{16'd1, 16'd1, 16'd0, 16'd2};
        t = '{16'd1, 16'd1, 16'd1, 16'd2};
        set_shapes(s, t);
        pending_indices.push_back(32'd0);
        s = '{16'd1, 16'd1, 16'd0, 16'd2};
        t = '{16'd1, 16'd1, 16'd7, 16'd2};
        set_shapes(s, t);
        pending_indices.push_back(32'd3);

        // Huge shapes: the count saturates and every index is in range.
        s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        t = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        set_shapes(s, t);
        pending_indices.push_back(32'hFFFF_FFFF);
        pending_indices.push_back(32'h0001_0000);
        pending_indices.push_back(32'hAAAA_5555);
        s = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF};
        t = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1};
        set_shapes(s, t);
        pending_indices.push_back(32'hFFFF_FFFF);
        pending_indices.push_back(32'h1234_5678);

        for (phase = 0; phase < 8; phase++)
        begin
            for (int i = 0; i < NUM_REG_DIMS; i++)
            begin
                s[i] = pick_dim();
                t[i] = ($urandom_range(3) == 0) ? pick_dim()
                     : (($urandom_range(1) == 0) ? s[i] : 16'd1);
                if (s[i] == 1 && $urandom_range(1) == 0)
                begin
                    t[i] = pick_dim();
                end
            end
            set_shapes(s, t);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            cnt = target_count();
            // The hold-off phase offers more items than the pipeline holds.
            for (int i = 0; i < ((phase == 4) ? 200 : 40); i++)
            begin
                pending_indices.push_back(pick_index(cnt));
            end
            if (phase == 4)
            begin
                // Long receiver hold-off while input keeps flowing, to fill the pipe.
                hold_off_cycles = 3 * LATENCY;
            end
        end

        wait_drained();
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[broadcast_source_index.f]
rtl/bsi_pkg.sv
rtl/bsi_shape.sv
rtl/bsi_axis.sv
rtl/broadcast_source_index.sv
tb/sv/broadcast_source_index_test.sv
